FILE: rtl/core/sleep_wakeup_queue_defines.svh
// Assertion macros used by the queue RTL.
`ifndef SLEEP_WAKEUP_QUEUE_DEFINES_SVH
`define SLEEP_WAKEUP_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
`define SQW_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`define SQW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SQW_ASSERT_IMPLY(label, clk, rst_n, pre, post, msg)
`define SQW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif

`endif

FILE: rtl/core/sqw_pkg.sv
`timescale 1ns / 1ps

package sqw_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);
  localparam int TICK_W      = 63;
  localparam int ID_W        = 8;
  localparam int DUR_W       = 32;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [0:0] {
    ACT_TICK  = 1'b0,
    ACT_SLEEP = 1'b1
  } action_t;

  typedef enum logic [0:0] {
    KIND_STATUS = 1'b0,
    KIND_WAKE   = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_QUEUED  = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_IRD,
    S_ICMP,
    S_STAT,
    S_TRD,
    S_TCMP,
    S_TFIN
  } state_t;

  typedef struct packed {
    logic [TICK_W-1:0] deadline;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    entry_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    status_t           status;
    logic [TICK_W-1:0] tick;
    logic              last;
  } result_t;

  typedef struct packed {
    logic idle;
    occ_t occ;
  } seq_stat_t;

  function automatic idx_t wrap_idx(idx_t head, occ_t off);
    logic [OCC_W:0] s;
    s = (OCC_W + 1)'(head) + (OCC_W + 1)'(off);
    if (s >= (OCC_W + 1)'(QUEUE_DEPTH)) begin
      s = s - (OCC_W + 1)'(QUEUE_DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

FILE: rtl/core/sleep_wakeup_queue.sv
`timescale 1ns / 1ps
`include "sleep_wakeup_queue_defines.svh"

// Channel   Direction  tuser   tlast  tdata (lowest bit first)
// in_       request    action  -      thread_id[7:0], duration[39:8]
// out_      result     kind    last   thread_id_res[7:0], status[9:8], tick_now[72:10]
//
// A nonpositive or dropped sleep request goes straight to its status result; a queued
// one first forms its deadline, then moves later entries up until an earlier or equal
// deadline stops the walk. A tick wakes due threads until one not yet due stops it.
// Reset empties the queue and clears the tick count; the entry memory is not cleared.
// in_tready is high only while the sequencer is idle; a low out_tready holds it
// at the next result, and the final result may wait while a new request is taken.

module sleep_wakeup_queue
  import sqw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // thread_id, duration
  input  logic [0:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // thread_id_res, status, tick_now, zero fill
  output logic [0:0]  out_tuser,  // kind
  output logic        out_tlast   // last
);

  mem_req_t  mem_req;
  entry_t    rd_data;
  logic      res_load;
  result_t   res;
  seq_stat_t stat;
  logic      res_free;
  logic      out_valid_r;
  result_t   out_res_r;

  sqw_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  sqw_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_action (action_t'(in_tuser[0])),
    .in_id     (in_tdata[ID_W-1:0]),
    .in_dur    (in_tdata[ID_W+DUR_W-1:ID_W]),
    .rd_data   (rd_data),
    .res_free  (res_free),
    .mem_req   (mem_req),
    .res_load  (res_load),
    .res       (res),
    .stat      (stat)
  );

  assign res_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign in_tready  = stat.idle;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_res_r.tick, out_res_r.status, out_res_r.id};
  assign out_tuser  = out_res_r.kind;
  assign out_tlast  = out_res_r.last;

  `SQW_ASSERT_IMPLY(a_occ_bound, clk, rst_n, 1'b1, stat.occ <= OCC_W'(QUEUE_DEPTH), "occupancy exceeds depth")
  `SQW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready right after a request")
  `SQW_ASSERT_IMPLY(a_status_last, clk, rst_n, out_tvalid && (out_tuser == KIND_STATUS), out_tlast, "status result not last")
  `SQW_ASSERT_IMPLY(a_wake_status, clk, rst_n, out_tvalid && (out_tuser == KIND_WAKE), out_tdata[9:8] == ST_QUEUED, "wake result with nonzero status")

endmodule

FILE: rtl/core/sqw_mem.sv
`timescale 1ns / 1ps

module sqw_mem
  import sqw_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/sqw_seq.sv
`timescale 1ns / 1ps

module sqw_seq
  import sqw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  action_t          in_action,
  input  logic [ID_W-1:0]  in_id,
  input  logic [DUR_W-1:0] in_dur,
  input  entry_t           rd_data,
  input  logic             res_free,
  output mem_req_t         mem_req,
  output logic             res_load,
  output result_t          res,
  output seq_stat_t        stat
);

  state_t            state_r, state_nxt;
  action_t           act_r, act_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [TICK_W-1:0] key_r, key_nxt;
  idx_t              head_r, head_nxt;
  occ_t              occ_r, occ_nxt;
  occ_t              j_r, j_nxt;
  logic [NRES_W-1:0] n_r, n_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  status_t           status_r, status_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;

  logic [TICK_W-1:0] addend;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] sum_sat;
  logic [TICK_W-1:0] cmp_key;
  logic              le;

  // One saturating adder serves both the deadline and the tick count.
  assign addend  = (act_r == ACT_SLEEP) ? key_r : TICK_W'(1);
  assign sum     = {1'b0, tick_r} + {1'b0, addend};
  assign sum_sat = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];

  // One comparator serves the insertion walk and the wake scan.
  assign cmp_key = (act_r == ACT_SLEEP) ? key_r : tick_r;
  assign le      = (rd_data.deadline <= cmp_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      tick_r   <= '0;
      head_r   <= '0;
      occ_r    <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    key_r     <= key_nxt;
    j_r       <= j_nxt;
    n_r       <= n_nxt;
    id_r      <= id_nxt;
    status_r  <= status_nxt;
    pend_id_r <= pend_id_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    tick_nxt    = tick_r;
    key_nxt     = key_r;
    head_nxt    = head_r;
    occ_nxt     = occ_r;
    j_nxt       = j_r;
    n_nxt       = n_r;
    id_nxt      = id_r;
    status_nxt  = status_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    mem_req     = '0;
    res_load    = 1'b0;
    res.kind    = KIND_STATUS;
    res.id      = id_r;
    res.status  = status_r;
    res.tick    = tick_r;
    res.last    = 1'b1;
    stat.idle   = 1'b0;
    stat.occ    = occ_r;

    unique case (state_r)
      S_IDLE: begin
        stat.idle = 1'b1;
        if (in_valid) begin
          act_nxt = in_action;
          id_nxt  = in_id;
          key_nxt = TICK_W'(in_dur);
          if (in_action == ACT_SLEEP) begin
            if (in_dur[DUR_W-1] || (in_dur == '0)) begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_STAT;
            end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
              status_nxt = ST_DROPPED;
              state_nxt  = S_STAT;
            end else begin
              status_nxt = ST_QUEUED;
              state_nxt  = S_ADD;
            end
          end else begin
            state_nxt = S_ADD;
          end
        end
      end

      S_ADD: begin
        if (act_r == ACT_SLEEP) begin
          key_nxt   = sum_sat;
          j_nxt     = occ_r;
          state_nxt = S_IRD;
        end else begin
          tick_nxt  = sum_sat;
          n_nxt     = '0;
          state_nxt = S_TRD;
        end
      end

      // The insertion walks from the tail toward the head, moving each later
      // deadline up by one slot until the new entry finds its place.
      S_IRD: begin
        if (j_r == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = head_r;
          mem_req.wdata = '{deadline: key_r, id: id_r};
          occ_nxt       = occ_r + OCC_W'(1);
          state_nxt     = S_STAT;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = wrap_idx(head_r, j_r - OCC_W'(1));
          state_nxt     = S_ICMP;
        end
      end

      S_ICMP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wrap_idx(head_r, j_r);
        if (!le) begin
          mem_req.wdata = rd_data;
          j_nxt         = j_r - OCC_W'(1);
          state_nxt     = S_IRD;
        end else begin
          mem_req.wdata = '{deadline: key_r, id: id_r};
          occ_nxt       = occ_r + OCC_W'(1);
          state_nxt     = S_STAT;
        end
      end

      S_STAT: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_TRD: begin
        if ((occ_r == '0) || (n_r == NRES_W'(MAX_RESULTS))) begin
          state_nxt = S_TFIN;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = head_r;
          state_nxt     = S_TCMP;
        end
      end

      // A woken entry is held back one step so that its last flag is known.
      S_TCMP: begin
        res.kind   = KIND_WAKE;
        res.id     = pend_id_r;
        res.status = ST_QUEUED;
        res.last   = 1'b0;
        if (!le) begin
          state_nxt = S_TFIN;
        end else if (!pend_v_r || res_free) begin
          res_load    = pend_v_r;
          pend_v_nxt  = 1'b1;
          pend_id_nxt = rd_data.id;
          head_nxt    = wrap_idx(head_r, OCC_W'(1));
          occ_nxt     = occ_r - OCC_W'(1);
          n_nxt       = n_r + NRES_W'(1);
          state_nxt   = S_TRD;
        end
      end

      S_TFIN: begin
        res.kind   = KIND_WAKE;
        res.id     = pend_id_r;
        res.status = ST_QUEUED;
        res.last   = 1'b1;
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (res_free) begin
          res_load   = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
